[hdl/clamped_start_cubic_spline_coefs_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the clamped-start cubic spline coefficient unit
// Short forms for clocked assertions on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef CLAMPED_START_CUBIC_SPLINE_COEFS_UNIT_MACROS_SVH
`define CLAMPED_START_CUBIC_SPLINE_COEFS_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CSCU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define CSCU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/cscu_pkg.sv]
// ----------------------------------------------------------------------------
// cscu_pkg
// Shared constants, types and helper functions of the spline coefficient unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cscu_pkg;

  localparam int unsigned KNOT_FRAC_BITS = 16;
  localparam int unsigned COEF_FRAC_BITS = 32;
  localparam int unsigned MAX_KNOTS      = 1024;

  localparam int unsigned KNOT_W = 32;
  localparam int unsigned COEF_W = 64;
  localparam int unsigned WIDE_W = 128;
  localparam int unsigned IDX_W  = 10;
  // Operand of the shared unit: multiplier bits or divisor, both below 2^34.
  localparam int unsigned OPC_W  = 34;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned DIV_STEPS = 64;

  localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } alu_op_e;

  typedef enum logic [2:0] {
    ALU_IDLE,
    ALU_MUL,
    ALU_DCHK,
    ALU_DIV,
    ALU_DFIN
  } alu_state_e;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_SLOPE,
    SQ_MUL_A,
    SQ_MUL_B,
    SQ_CNUM,
    SQ_CDIV,
    SQ_DDIV,
    SQ_BMUL,
    SQ_BDIV,
    SQ_HOLD
  } seq_state_e;

  // Request to the shared unit. For a multiply the result is
  // opa + opb * opc; for a divide it is opa / opc rounded toward zero.
  typedef struct packed {
    logic              start;
    alu_op_e           op;
    logic [WIDE_W-1:0] opa;
    logic [WIDE_W-1:0] opb;
    logic [OPC_W-1:0]  opc;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [WIDE_W-1:0] result;
  } alu_rsp_t;

  function automatic logic [WIDE_W-1:0] sext64(input logic [COEF_W-1:0] v);
    return {{(WIDE_W-COEF_W){v[COEF_W-1]}}, v};
  endfunction

  function automatic logic [WIDE_W-1:0] sext32(input logic [KNOT_W-1:0] v);
    return {{(WIDE_W-KNOT_W){v[KNOT_W-1]}}, v};
  endfunction

  // Saturate a 128-bit two's complement value to the 64-bit range.
  function automatic logic [COEF_W-1:0] sat64(input logic [WIDE_W-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[WIDE_W-1:COEF_W-1];
    all_zero = ~|v[WIDE_W-1:COEF_W-1];
    if (all_one || all_zero) begin
      return v[COEF_W-1:0];
    end
    return v[WIDE_W-1] ? COEF_MIN : COEF_MAX;
  endfunction

endpackage

`default_nettype wire

[hdl/cscu_alu.sv]
// ----------------------------------------------------------------------------
// cscu_alu
// Shared iterative unit: shift-add multiply-accumulate and restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

module cscu_alu (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cscu_pkg::alu_req_t req_i,
  output cscu_pkg::alu_rsp_t      rsp_o
);

  cscu_pkg::alu_state_e state_q, state_d;

  logic [cscu_pkg::WIDE_W-1:0] acc_q;
  logic [cscu_pkg::WIDE_W-1:0] opb_q;
  logic [cscu_pkg::OPC_W-1:0]  opc_q;
  logic [cscu_pkg::OPC_W-1:0]  rem_q;
  logic [cscu_pkg::CNT_W-1:0]  cnt_q;
  logic                        neg_q;
  logic                        done_q;

  logic [cscu_pkg::OPC_W:0]    rem_sh;
  logic                        rem_ge;
  logic                        hi_ge;
  logic [cscu_pkg::COEF_W-1:0] quo;
  logic                        last_step;

  assign rem_sh    = {rem_q, acc_q[cscu_pkg::COEF_W-1]};
  assign rem_ge    = rem_sh >= {1'b0, opc_q};
  assign hi_ge     = acc_q[cscu_pkg::WIDE_W-1:cscu_pkg::COEF_W] >=
                     {{(cscu_pkg::COEF_W-cscu_pkg::OPC_W){1'b0}}, opc_q};
  assign quo       = acc_q[cscu_pkg::COEF_W-1:0];
  assign last_step = cnt_q == cscu_pkg::CNT_W'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cscu_pkg::ALU_IDLE: begin
        if (req_i.start) begin
          state_d = (req_i.op == cscu_pkg::OP_MUL) ? cscu_pkg::ALU_MUL : cscu_pkg::ALU_DCHK;
        end
      end
      cscu_pkg::ALU_MUL:  if (last_step) state_d = cscu_pkg::ALU_IDLE;
      cscu_pkg::ALU_DCHK: state_d = hi_ge ? cscu_pkg::ALU_IDLE : cscu_pkg::ALU_DIV;
      cscu_pkg::ALU_DIV:  if (last_step) state_d = cscu_pkg::ALU_DFIN;
      cscu_pkg::ALU_DFIN: state_d = cscu_pkg::ALU_IDLE;
      default:            state_d = cscu_pkg::ALU_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    rsp_o.done   = done_q;
    rsp_o.result = acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cscu_pkg::ALU_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == cscu_pkg::ALU_MUL && last_step) ||
                 (state_q == cscu_pkg::ALU_DCHK && hi_ge) ||
                 (state_q == cscu_pkg::ALU_DFIN);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      cscu_pkg::ALU_IDLE: begin
        if (req_i.start) begin
          opc_q <= req_i.opc;
          opb_q <= req_i.opb;
          neg_q <= req_i.opa[cscu_pkg::WIDE_W-1];
          if (req_i.op == cscu_pkg::OP_MUL) begin
            acc_q <= req_i.opa;
            cnt_q <= cscu_pkg::CNT_W'(cscu_pkg::OPC_W);
          end else begin
            acc_q <= req_i.opa[cscu_pkg::WIDE_W-1] ? (~req_i.opa + 1'b1) : req_i.opa;
          end
        end
      end
      cscu_pkg::ALU_MUL: begin
        if (opc_q[0]) begin
          acc_q <= acc_q + opb_q;
        end
        opb_q <= opb_q << 1;
        opc_q <= opc_q >> 1;
        cnt_q <= cnt_q - 1'b1;
      end
      cscu_pkg::ALU_DCHK: begin
        if (hi_ge) begin
          acc_q[cscu_pkg::COEF_W-1:0] <= neg_q ? cscu_pkg::COEF_MIN : cscu_pkg::COEF_MAX;
        end
        rem_q <= acc_q[cscu_pkg::COEF_W +: cscu_pkg::OPC_W];
        cnt_q <= cscu_pkg::CNT_W'(cscu_pkg::DIV_STEPS);
      end
      cscu_pkg::ALU_DIV: begin
        rem_q <= rem_ge ? cscu_pkg::OPC_W'(rem_sh - {1'b0, opc_q})
                        : rem_sh[cscu_pkg::OPC_W-1:0];
        acc_q[cscu_pkg::COEF_W-1:0] <= {acc_q[cscu_pkg::COEF_W-2:0], rem_ge};
        cnt_q <= cnt_q - 1'b1;
      end
      cscu_pkg::ALU_DFIN: begin
        if (neg_q) begin
          acc_q[cscu_pkg::COEF_W-1:0] <= (quo > cscu_pkg::COEF_MIN) ? cscu_pkg::COEF_MIN
                                                                  : (~quo + 1'b1);
        end else begin
          acc_q[cscu_pkg::COEF_W-1:0] <= quo[cscu_pkg::COEF_W-1] ? cscu_pkg::COEF_MAX : quo;
        end
        acc_q[cscu_pkg::WIDE_W-1:cscu_pkg::COEF_W] <= '0;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[hdl/clamped_start_cubic_spline_coefs_unit.sv]
// ----------------------------------------------------------------------------
// clamped_start_cubic_spline_coefs_unit
// Streams spline knots and emits the cubic coefficients of each segment.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  s_axis    in         knot_x, knot_y in tdata; first_knot in tuser
//  m_axis    out        segment_index, coef_a..coef_d in tdata; spacing_error in tuser
//  cfg       in         start_slope (index 0), start_curvature (index 1)
//
// A first knot (or any knot before a spline has started) yields no
// result, and so does a knot that arrives once the spline is full. Any
// other knot with positive spacing runs through one shared multiply/divide
// unit: four divides and three multiplies (two for a spline's second knot).
// A knot whose spacing is not positive skips the shared unit and gives an
// error result. The result waits in an output register; a stalled output
// holds the sequencer in its final state until the result is taken. Reset
// is asynchronous and clears the knot count, state and configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module clamped_start_cubic_spline_coefs_unit #(
  parameter int unsigned MAX_KNOTS = cscu_pkg::MAX_KNOTS
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Knot request: [31:0] knot_x, [63:32] knot_y
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [63:0]  s_axis_tdata_i,
  // [0] first_knot
  input  wire logic         s_axis_tuser_i,
  // Result: [9:0] segment_index, [73:10] coef_a, [137:74] coef_b,
  // [201:138] coef_c, [265:202] coef_d, [271:266] zero
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [271:0]      m_axis_tdata_o,
  // [0] spacing_error
  output logic              m_axis_tuser_o,
  // Configuration write port
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i
);

  localparam int unsigned KC_W = $clog2(MAX_KNOTS + 1);
  localparam int unsigned KW   = cscu_pkg::KNOT_W;
  localparam int unsigned CW   = cscu_pkg::COEF_W;
  localparam int unsigned WW   = cscu_pkg::WIDE_W;
  localparam int unsigned KF   = cscu_pkg::KNOT_FRAC_BITS;
  localparam int unsigned CF   = cscu_pkg::COEF_FRAC_BITS;
  localparam logic        CFG_SLOPE = 1'b0;
  localparam logic        CFG_CURV  = 1'b1;

  // Configuration registers
  logic [KW-1:0] slope_q, curv_q;

  // Spline state
  logic [KW-1:0]   prev_x_q, prev_y_q, prev_h_q;
  logic [CW-1:0]   s_last_q, c_last_q, c_bl_q;
  logic [KC_W-1:0] cnt_q;

  // Knot in flight
  logic [KW-1:0] x_q, y_q, h_q;
  logic [CW-1:0] s1_q, tmp_q, cnew_q, d_q, b_q;
  logic          err_q;
  logic          launched_q;

  // Output register
  logic                       out_valid_q;
  logic [cscu_pkg::IDX_W-1:0] out_idx_q;
  logic [CW-1:0]              out_a_q, out_b_q, out_c_q, out_d_q;
  logic                       out_err_q;

  cscu_pkg::seq_state_e state_q, state_d;
  cscu_pkg::alu_req_t   alu_req;
  cscu_pkg::alu_rsp_t   alu_rsp;

  logic          in_acc, restart, full, sec_knot, out_free;
  logic [KW:0]   h_full;
  logic          h_bad;
  logic [WW-1:0] prod_k, s1x3, slx3, sl_sh, cdiff;
  logic [CW-1:0] mi1, mi2;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign restart  = s_axis_tuser_i || (cnt_q == '0);
  assign full     = cnt_q >= KC_W'(MAX_KNOTS);
  assign sec_knot = cnt_q == KC_W'(1);
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign h_full   = {s_axis_tdata_i[KW-1], s_axis_tdata_i[KW-1:0]} -
                    {prev_x_q[KW-1], prev_x_q};
  assign h_bad    = h_full[KW] || (h_full == '0);

  // Terms of the c numerator
  assign prod_k = WW'($signed(alu_rsp.result) >>> KF);
  assign s1x3   = (cscu_pkg::sext64(s1_q) << 1) + cscu_pkg::sext64(s1_q);
  assign slx3   = (cscu_pkg::sext32(slope_q) << 1) + cscu_pkg::sext32(slope_q);
  assign sl_sh  = slx3 << (CF - KF);
  assign mi1    = cscu_pkg::sat64(s1x3 - ((cscu_pkg::sext64(s_last_q) << 1) +
                                          cscu_pkg::sext64(s_last_q)));
  assign mi2    = cscu_pkg::sat64(prod_k);
  assign cdiff  = cscu_pkg::sext64(cnew_q) - cscu_pkg::sext64(c_last_q);

  cscu_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  // Next state of the sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cscu_pkg::SQ_IDLE: begin
        if (in_acc && !restart && !full) begin
          state_d = h_bad ? cscu_pkg::SQ_HOLD : cscu_pkg::SQ_SLOPE;
        end
      end
      cscu_pkg::SQ_SLOPE: begin
        if (alu_rsp.done) state_d = sec_knot ? cscu_pkg::SQ_MUL_B : cscu_pkg::SQ_MUL_A;
      end
      cscu_pkg::SQ_MUL_A: if (alu_rsp.done) state_d = cscu_pkg::SQ_MUL_B;
      cscu_pkg::SQ_MUL_B: if (alu_rsp.done) state_d = cscu_pkg::SQ_CNUM;
      cscu_pkg::SQ_CNUM:  state_d = cscu_pkg::SQ_CDIV;
      cscu_pkg::SQ_CDIV:  if (alu_rsp.done) state_d = cscu_pkg::SQ_DDIV;
      cscu_pkg::SQ_DDIV:  if (alu_rsp.done) state_d = cscu_pkg::SQ_BMUL;
      cscu_pkg::SQ_BMUL:  if (alu_rsp.done) state_d = cscu_pkg::SQ_BDIV;
      cscu_pkg::SQ_BDIV:  if (alu_rsp.done) state_d = cscu_pkg::SQ_HOLD;
      cscu_pkg::SQ_HOLD:  if (out_free) state_d = cscu_pkg::SQ_IDLE;
      default:            state_d = cscu_pkg::SQ_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and the request to the shared unit
  always_comb begin
    s_axis_tready_o = state_q == cscu_pkg::SQ_IDLE;
    alu_req.start   = 1'b0;
    alu_req.op      = cscu_pkg::OP_DIV;
    alu_req.opa     = '0;
    alu_req.opb     = '0;
    alu_req.opc     = cscu_pkg::OPC_W'(h_q);
    unique case (state_q)
      cscu_pkg::SQ_SLOPE: begin
        alu_req.start = !launched_q;
        alu_req.opa   = cscu_pkg::sext32(y_q - prev_y_q) << CF;
        // The subtraction may wrap at 32 bits; rebuild it at 33.
        alu_req.opa   = (WW'($signed({y_q[KW-1], y_q}) - $signed({prev_y_q[KW-1], prev_y_q})))
                        << CF;
      end
      cscu_pkg::SQ_MUL_A: begin
        alu_req.start = !launched_q;
        alu_req.op    = cscu_pkg::OP_MUL;
        alu_req.opb   = cscu_pkg::sext64(c_bl_q);
        alu_req.opc   = cscu_pkg::OPC_W'(prev_h_q);
      end
      cscu_pkg::SQ_MUL_B: begin
        alu_req.start = !launched_q;
        alu_req.op    = cscu_pkg::OP_MUL;
        alu_req.opa   = sec_knot ? '0 : alu_rsp.result;
        alu_req.opb   = cscu_pkg::sext64(c_last_q);
        alu_req.opc   = sec_knot ? {1'b0, h_q, 1'b0}
                                 : {({1'b0, prev_h_q} + {1'b0, h_q}), 1'b0};
      end
      cscu_pkg::SQ_CDIV: begin
        alu_req.start = !launched_q;
        alu_req.opa   = cscu_pkg::sext64(tmp_q) << KF;
      end
      cscu_pkg::SQ_DDIV: begin
        alu_req.start = !launched_q;
        alu_req.opa   = cscu_pkg::sext64(cscu_pkg::sat64(cdiff)) << KF;
        alu_req.opc   = {2'b00, h_q} + {1'b0, h_q, 1'b0};
      end
      cscu_pkg::SQ_BMUL: begin
        alu_req.start = !launched_q;
        alu_req.op    = cscu_pkg::OP_MUL;
        alu_req.opb   = cscu_pkg::sext64(cnew_q) + (cscu_pkg::sext64(c_last_q) << 1);
      end
      cscu_pkg::SQ_BDIV: begin
        alu_req.start = !launched_q;
        alu_req.opa   = alu_rsp.result;
        alu_req.opc   = cscu_pkg::OPC_W'(3) << KF;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cscu_pkg::SQ_IDLE;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      slope_q     <= '0;
      curv_q      <= '0;
    end else begin
      state_q <= state_d;
      if (alu_req.start) begin
        launched_q <= 1'b1;
      end else if (alu_rsp.done) begin
        launched_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SLOPE: slope_q <= cfg_data_i;
          CFG_CURV:  curv_q  <= cfg_data_i;
          default:   ;
        endcase
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == cscu_pkg::SQ_HOLD && out_free) begin
        out_valid_q <= 1'b1;
        if (!err_q) cnt_q <= cnt_q + 1'b1;
      end
      if (in_acc && restart) begin
        cnt_q <= KC_W'(1);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q   <= s_axis_tdata_i[KW-1:0];
      y_q   <= s_axis_tdata_i[2*KW-1:KW];
      h_q   <= h_full[KW-1:0];
      err_q <= h_bad;
      if (restart) begin
        // A new spline starts: c0 is half the start curvature.
        prev_x_q <= s_axis_tdata_i[KW-1:0];
        prev_y_q <= s_axis_tdata_i[2*KW-1:KW];
        prev_h_q <= '0;
        s_last_q <= '0;
        c_bl_q   <= '0;
        c_last_q <= cscu_pkg::sat64(cscu_pkg::sext32(curv_q) << (CF - KF - 1));
      end
    end
    if (alu_rsp.done) begin
      unique case (state_q)
        cscu_pkg::SQ_SLOPE: s1_q   <= alu_rsp.result[CW-1:0];
        cscu_pkg::SQ_CDIV:  cnew_q <= alu_rsp.result[CW-1:0];
        cscu_pkg::SQ_DDIV:  d_q    <= alu_rsp.result[CW-1:0];
        cscu_pkg::SQ_BDIV:  b_q    <= cscu_pkg::sat64(cscu_pkg::sext64(s1_q) -
                                                      cscu_pkg::sext64(alu_rsp.result[CW-1:0]));
        default: ;
      endcase
    end
    if (state_q == cscu_pkg::SQ_CNUM) begin
      if (sec_knot) begin
        tmp_q <= cscu_pkg::sat64(s1x3 - sl_sh - prod_k);
      end else begin
        tmp_q <= cscu_pkg::sat64(cscu_pkg::sext64(mi1) - cscu_pkg::sext64(mi2));
      end
    end
    if (state_q == cscu_pkg::SQ_HOLD && out_free) begin
      out_idx_q <= cscu_pkg::IDX_W'(32'(cnt_q) - 32'd1);
      out_err_q <= err_q;
      if (err_q) begin
        out_a_q <= '0;
        out_b_q <= '0;
        out_c_q <= '0;
        out_d_q <= '0;
      end else begin
        out_a_q  <= cscu_pkg::sat64(cscu_pkg::sext32(prev_y_q) << (CF - KF));
        out_b_q  <= b_q;
        out_c_q  <= c_last_q;
        out_d_q  <= d_q;
        // Advance the spline state by one knot.
        prev_x_q <= x_q;
        prev_y_q <= y_q;
        prev_h_q <= h_q;
        s_last_q <= s1_q;
        c_bl_q   <= c_last_q;
        c_last_q <= cnew_q;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_err_q;
  assign m_axis_tdata_o  = {6'b0, out_d_q, out_c_q, out_b_q, out_a_q, out_idx_q};

endmodule

`default_nettype wire

[hdl/cscu_chk.sv]
// ----------------------------------------------------------------------------
// cscu_chk
// Port-level checks of the spline coefficient unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "clamped_start_cubic_spline_coefs_unit_macros.svh"

module cscu_chk (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid_i,
  input wire logic         s_axis_tready_o,
  input wire logic         s_axis_tuser_i,
  input wire logic         m_axis_tvalid_o,
  input wire logic         m_axis_tready_i,
  input wire logic [271:0] m_axis_tdata_o,
  input wire logic         m_axis_tuser_o
);

  logic s_acc, m_stall;

  assign s_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign m_stall = m_axis_tvalid_o && !m_axis_tready_i;

  `CSCU_ASSERT_NEXT(a_out_valid_holds, m_stall, m_axis_tvalid_o)
  `CSCU_ASSERT_NEXT(a_out_data_holds, m_stall, $stable(m_axis_tdata_o))
  `CSCU_ASSERT_NEXT(a_restart_silent, s_acc && s_axis_tuser_i && !m_axis_tvalid_o,
                    !m_axis_tvalid_o)
  `CSCU_ASSERT_NOW(a_error_zero_coefs, m_axis_tvalid_o && m_axis_tuser_o,
                   m_axis_tdata_o[271:10] == '0)

endmodule

bind clamped_start_cubic_spline_coefs_unit cscu_chk u_cscu_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the clamped-start cubic spline coefficient unit.
// Knot requests are streamed in bursts. A built-in fixed-point model predicts
// the coefficients of every segment, and each result taken from the output
// stream is compared field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  import cscu_pkg::*;

  // Register map of the configuration port.
  localparam logic REG_START_SLOPE     = 1'b0;
  localparam logic REG_START_CURVATURE = 1'b1;

  localparam int unsigned IDLE_LIMIT   = 6000;
  localparam int unsigned SETTLE_WAIT  = 20;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam logic signed [63:0] Q_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [63:0]  s64_t;

  // One segment result as it leaves the unit.
  typedef struct {
    logic [9:0]  seg_idx;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
    logic        spacing_err;
  } segment_t;

  logic clk_i;
  logic rst_ni;

  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [63:0]  s_axis_tdata_i;   // [31:0] knot_x, [63:32] knot_y
  logic         s_axis_tuser_i;   // [0] first_knot
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [271:0] m_axis_tdata_o;   // [9:0] index, then coef_a, coef_b, coef_c, coef_d
  logic         m_axis_tuser_o;   // [0] spacing_error
  logic         cfg_we_i;
  logic         cfg_idx_i;
  logic [31:0]  cfg_data_i;

  clamped_start_cubic_spline_coefs_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Clock: 4 ns period.
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Model state. It mirrors what the unit keeps between knots, plus its own
  // copy of the two configuration registers.
  // --------------------------------------------------------------------------
  s64_t        slope_reg;
  s64_t        curv_reg;
  s64_t        last_x;
  s64_t        last_y;
  s64_t        older_y;
  logic [63:0] last_h;
  s64_t        c_cur;
  s64_t        c_old;
  int unsigned knots_held;

  segment_t pending_segs[$];
  int unsigned mismatches;
  int unsigned segs_seen;
  int unsigned err_segs_seen;
  int unsigned knots_sent;
  int unsigned idle_cycles;
  int unsigned burst_left;
  bit          timed_out;

  // Clamp a 128-bit value to the signed 64-bit range.
  function automatic s64_t clamp_q(input wide_t v);
    if (v > wide_t'(Q_MAX)) return Q_MAX;
    if (v < wide_t'(Q_MIN)) return Q_MIN;
    return v[63:0];
  endfunction

  function automatic wide_t widen(input s64_t v);
    return v;
  endfunction

  // Signed value times an unsigned factor, exact in 128 bits.
  function automatic wide_t mul_u(input s64_t a, input logic [63:0] f);
    wide_t fw;
    fw = {64'd0, f};
    return widen(a) * fw;
  endfunction

  function automatic s64_t diff_sat(input s64_t a, input s64_t b);
    return clamp_q(widen(a) - widen(b));
  endfunction

  // Division by a positive value, truncating toward zero, saturating.
  function automatic s64_t div_trunc(input wide_t num, input logic [63:0] den);
    logic [127:0] mag;
    logic [127:0] quo;
    bit           neg;
    if (den == 64'd0) return 64'sd0;
    neg = num[127];
    mag = neg ? -num : num;
    if (mag[127:64] >= den) return neg ? Q_MIN : Q_MAX;
    quo = mag / {64'd0, den};
    if (neg) return (quo[63:0] > 64'h8000_0000_0000_0000) ? Q_MIN : -quo[63:0];
    return quo[63] ? Q_MAX : quo[63:0];
  endfunction

  // Take one knot into the model. Returns 1 with the segment filled in when
  // the knot closes a segment (or is rejected for its spacing).
  function automatic bit spline_segment_for(input logic [31:0] kx, input logic [31:0] ky,
                                            input logic first, output segment_t seg);
    s64_t        x, y, h, s1, s2, c_new, mi1, mi2;
    logic [63:0] hu;
    wide_t       acc;
    x = s64_t'(signed'(kx));
    y = s64_t'(signed'(ky));
    seg = '{default: '0};
    // A new spline starts here, also when no spline has been started yet.
    if (first || knots_held == 0) begin
      last_x     = x;
      last_y     = y;
      older_y    = 0;
      last_h     = 0;
      c_old      = 0;
      c_cur      = clamp_q(widen(curv_reg) <<< (COEF_FRAC_BITS - KNOT_FRAC_BITS - 1));
      knots_held = 1;
      return 1'b0;
    end
    // A full spline ignores further knots until the next first knot.
    if (knots_held >= MAX_KNOTS) return 1'b0;
    seg.seg_idx = 10'(knots_held - 1);
    h = x - last_x;
    if (h <= 0) begin
      seg.spacing_err = 1'b1;
      return 1'b1;
    end
    hu = h;
    s1 = div_trunc(widen(y - last_y) <<< COEF_FRAC_BITS, hu);
    if (knots_held == 1) begin
      acc = mul_u(s1, 64'd3)
          - (mul_u(slope_reg, 64'd3) <<< (COEF_FRAC_BITS - KNOT_FRAC_BITS))
          - (mul_u(c_cur, 2 * hu) >>> KNOT_FRAC_BITS);
      c_new = div_trunc(widen(clamp_q(acc)) <<< KNOT_FRAC_BITS, hu);
    end else begin
      s2  = div_trunc(widen(last_y - older_y) <<< COEF_FRAC_BITS, last_h);
      mi1 = clamp_q(mul_u(s1, 64'd3) - mul_u(s2, 64'd3));
      acc = mul_u(c_old, last_h) + mul_u(c_cur, 2 * (last_h + hu));
      mi2 = clamp_q(acc >>> KNOT_FRAC_BITS);
      c_new = div_trunc(widen(diff_sat(mi1, mi2)) <<< KNOT_FRAC_BITS, hu);
    end
    seg.d = div_trunc(widen(diff_sat(c_new, c_cur)) <<< KNOT_FRAC_BITS, 3 * hu);
    seg.b = diff_sat(s1, div_trunc(mul_u(c_new, hu) + mul_u(c_cur, 2 * hu),
                                   64'd3 << KNOT_FRAC_BITS));
    seg.a = clamp_q(widen(last_y) <<< (COEF_FRAC_BITS - KNOT_FRAC_BITS));
    seg.c = c_cur;
    older_y    = last_y;
    last_y     = y;
    last_x     = x;
    last_h     = hu;
    c_old      = c_cur;
    c_cur      = c_new;
    knots_held = knots_held + 1;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: every accepted result is matched against the oldest
  // prediction. Only the first few mismatches are printed in full.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    segment_t want;
    segment_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.seg_idx     = m_axis_tdata_o[9:0];
      got.a           = m_axis_tdata_o[73:10];
      got.b           = m_axis_tdata_o[137:74];
      got.c           = m_axis_tdata_o[201:138];
      got.d           = m_axis_tdata_o[265:202];
      got.spacing_err = m_axis_tuser_o;
      segs_seen++;
      if (got.spacing_err) err_segs_seen++;
      if (pending_segs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: index %0d", got.seg_idx);
      end else begin
        want = pending_segs.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("segment mismatch (expected / actual):");
            $display("  index %0d / %0d, error %0b / %0b", want.seg_idx, got.seg_idx,
                     want.spacing_err, got.spacing_err);
            $display("  a %h / %h, b %h / %h", want.a, got.a, want.b, got.b);
            $display("  c %h / %h, d %h / %h", want.c, got.c, want.d, got.d);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: counts cycles in which neither stream moves. The limit covers a
  // knot's pass through the shared multiply/divide unit, the longest output
  // stall and request gap, with a wide margin over that.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)
        || cfg_we_i || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output back-pressure: randomly chosen stretches of always ready, random
  // ready and solid stalls.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stretch;
    int unsigned mode;
    m_axis_tready_i = 1'b0;
    forever begin
      mode    = $urandom_range(0, 2);
      stretch = (mode == 2) ? $urandom_range(1, 60) : $urandom_range(20, 900);
      repeat (stretch) begin
        @(negedge clk_i);
        case (mode)
          0: begin
            m_axis_tready_i <= 1'b1;
          end
          1: begin
            m_axis_tready_i <= $urandom_range(0, 1);
          end
          default: begin
            m_axis_tready_i <= 1'b0;
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared tasks.
  // --------------------------------------------------------------------------

  // Configuration writes only happen while the unit is idle.
  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == REG_START_SLOPE) slope_reg = s64_t'(signed'(val));
    else curv_reg = s64_t'(signed'(val));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Sends one knot request, with a random gap between bursts, and records
  // the predicted segment once the request has been accepted.
  task automatic send_knot(input logic [31:0] kx, input logic [31:0] ky,
                           input logic first);
    int unsigned gap;
    segment_t    seg;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {ky, kx};
    s_axis_tuser_i  <= first;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    knots_sent++;
    if (spline_segment_for(kx, ky, first, seg)) pending_segs.push_back(seg);
  endtask

  // Waits for every predicted result, then lets a first knot still in the
  // unit settle before a register may be written.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Edge cases: a knot before any spline, register extremes, equal and
  // falling abscissae, extreme ordinates and spacings of one and huge.
  task automatic test_directed();
    write_reg(REG_START_SLOPE, 32'h7fff_ffff);
    write_reg(REG_START_CURVATURE, 32'h8000_0000);
    // No spline has been started: this knot opens one although unflagged.
    send_knot(32'h0000_0000, 32'h0001_0000, 1'b0);
    send_knot(32'h0001_0000, 32'h7fff_ffff, 1'b0);
    send_knot(32'h0001_0000, 32'h0000_0000, 1'b0);   // zero spacing
    send_knot(32'h0000_8000, 32'h0000_0000, 1'b0);   // negative spacing
    send_knot(32'h0001_0001, 32'h8000_0000, 1'b0);   // spacing of one
    send_knot(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);   // very wide spacing
    send_knot(32'h8000_0000, 32'h0000_0000, 1'b1);
    send_knot(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_knot(32'h8000_0000, 32'h1234_5678, 1'b0);   // far backwards
    drain();
    write_reg(REG_START_SLOPE, 32'h8000_0000);
    write_reg(REG_START_CURVATURE, 32'h7fff_ffff);
    send_knot(32'hffff_0000, 32'hffff_ffff, 1'b1);
    send_knot(32'hffff_0001, 32'h7fff_ffff, 1'b0);
    send_knot(32'h0000_0000, 32'h8000_0000, 1'b0);
    send_knot(32'h0000_0003, 32'h7fff_ffff, 1'b0);
    send_knot(32'h0010_0000, 32'h0000_0000, 1'b0);
    send_knot(32'h0010_0000, 32'h0000_0000, 1'b1);   // restart on same x
    send_knot(32'h0020_0000, 32'h0001_0000, 1'b0);
    drain();
    write_reg(REG_START_SLOPE, 32'h0000_0000);
    write_reg(REG_START_CURVATURE, 32'h0000_0000);
    send_knot(32'h0000_0000, 32'h0000_0000, 1'b1);
    send_knot(32'h0001_0000, 32'h0001_0000, 1'b0);
    send_knot(32'h0002_0000, 32'h0000_0000, 1'b0);
    send_knot(32'h0003_0000, 32'h0001_0000, 1'b0);
    drain();
  endtask

  // Fills one spline to its knot limit; the knots after that are ignored
  // until a first knot starts the next spline.
  task automatic test_full_spline();
    longint kx;
    kx = -64'sd2000000000;
    write_reg(REG_START_SLOPE, $urandom);
    write_reg(REG_START_CURVATURE, $urandom);
    send_knot(32'(kx), $urandom, 1'b1);
    repeat (MAX_KNOTS + 3) begin
      kx += $urandom_range(1, 1 << 20);
      send_knot(32'(kx), $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 18),
                1'b0);
    end
    send_knot(32'h0000_0000, $urandom, 1'b1);
    send_knot(32'h0000_4000, $urandom, 1'b0);
    drain();
  endtask

  // Random splines: mostly well-formed runs with random content, with some
  // bad spacings, restarts and pure noise mixed in.
  task automatic test_random_splines(input int unsigned n_knots);
    longint      kx;
    longint      step;
    int unsigned sent;
    int unsigned pick;
    int unsigned run_len;
    logic [31:0] ky;
    sent = 0;
    while (sent < n_knots) begin
      kx = $urandom_range(0, 1) ? longint'($signed($urandom)) : $urandom_range(0, 1 << 20);
      send_knot(32'(kx), $urandom, 1'b1);
      sent++;
      run_len = $urandom_range(2, 14);
      repeat (run_len) begin
        pick = $urandom_range(0, 99);
        ky = $urandom_range(0, 2) == 0 ? $urandom_range(0, 1 << 17) - (1 << 16) : $urandom;
        if (pick < 6) begin
          // Spacing of zero or below.
          send_knot(32'(kx - $urandom_range(0, 3000)), ky, 1'b0);
        end else if (pick < 10) begin
          send_knot($urandom, $urandom, $urandom_range(0, 1));
        end else begin
          case ($urandom_range(0, 3))
            0: step = $urandom_range(1, 16);
            1: step = longint'($urandom_range(1, 1 << 30)) * 2;
            default: step = $urandom_range(1 << 12, 1 << 20);
          endcase
          if (kx + step > 64'sd2147483647) break;
          kx += step;
          send_knot(32'(kx), ky, 1'b0);
        end
        sent++;
      end
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_START_SLOPE;
    cfg_data_i      = '0;
    slope_reg       = 0;
    curv_reg        = 0;
    last_x          = 0;
    last_y          = 0;
    older_y         = 0;
    last_h          = 0;
    c_cur           = 0;
    c_old           = 0;
    knots_held      = 0;
    mismatches      = 0;
    segs_seen       = 0;
    err_segs_seen   = 0;
    knots_sent      = 0;
    idle_cycles     = 0;
    burst_left      = 0;
    timed_out       = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_full_spline();
    // Random content under several register settings, extremes included.
    write_reg(REG_START_SLOPE, 32'h0001_0000);
    write_reg(REG_START_CURVATURE, 32'hffff_0000);
    test_random_splines(110);
    write_reg(REG_START_SLOPE, $urandom);
    write_reg(REG_START_CURVATURE, $urandom);
    test_random_splines(110);
    write_reg(REG_START_SLOPE, 32'h8000_0000);
    write_reg(REG_START_CURVATURE, 32'h8000_0000);
    test_random_splines(110);
    write_reg(REG_START_SLOPE, $urandom_range(0, 1 << 18));
    write_reg(REG_START_CURVATURE, 32'h7fff_ffff);
    test_random_splines(110);

    repeat (100) @(posedge clk_i);
    $display("Sent %0d knots; checked %0d segments, %0d of them spacing errors.",
             knots_sent, segs_seen, err_segs_seen);
    $display("Covered restarts, a full spline, register extremes and %0d mismatches.",
             mismatches);
    if (mismatches == 0 && pending_segs.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
